// ===== rtl/ebj_pkg.sv =====
// Shared widths, register indexes, sequencer states and unit types for the backoff core.
package ebj_pkg;

   localparam int DELAY_WIDTH   = 20;
   localparam int JITTER_WIDTH  = 32;
   localparam int ATTEMPT_WIDTH = 16;
   localparam int CSR_IDX_WIDTH = 4;

   // doubled delay needs one bit of headroom before the cap
   localparam int UNIT_WIDTH    = DELAY_WIDTH + 1;
   localparam int WAIT_WIDTH    = DELAY_WIDTH + 1;
   // delay/4 + 1 reaches at most 2**(DELAY_WIDTH-2)
   localparam int SPREAD_WIDTH  = DELAY_WIDTH - 1;
   localparam int BIT_CNT_WIDTH = $clog2(JITTER_WIDTH);

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BASE_DELAY = CSR_IDX_WIDTH'(0);
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MAX_DELAY  = CSR_IDX_WIDTH'(1);

   localparam logic [DELAY_WIDTH-1:0] BASE_DELAY_RESET = DELAY_WIDTH'(500);
   localparam logic [DELAY_WIDTH-1:0] MAX_DELAY_RESET  = DELAY_WIDTH'(30000);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DOUBLE,
      ST_CAP,
      ST_DIVIDE,
      ST_FINISH
   } seq_state_type;

   typedef struct packed {
      logic [UNIT_WIDTH-1:0] a;
      logic [UNIT_WIDTH-1:0] b;
   } unit_op_type;

   typedef struct packed {
      logic                  borrow;
      logic [UNIT_WIDTH-1:0] diff;
   } unit_res_type;

endpackage

// ===== rtl/exponential_backoff_jitter_core.sv =====
// Top level of the capped exponential backoff core with jitter.
// An item is taken only while the sequencer is idle. The core then runs one doubling
// step per cycle until the attempt count runs out, the delay reaches the ceiling, or
// the delay is zero. That is at most DELAY_WIDTH doubling steps. Then come the cap
// step, a restoring remainder over the JITTER_WIDTH jitter bits (one jitter bit per
// cycle), and the load of the output register. The doubling, cap and remainder steps
// share a single subtract/compare unit. The load, and so the result beat, waits while
// the previous result is still stalled in the output register. The next item can be
// taken in the cycle after the load. A new item may be accepted while the previous
// result still waits in the output register.
module exponential_backoff_jitter_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [ebj_pkg::ATTEMPT_WIDTH-1:0]  req_attempt_number,
   input  logic [ebj_pkg::JITTER_WIDTH-1:0]   req_jitter_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ebj_pkg::WAIT_WIDTH-1:0]     rsp_wait_ms,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ebj_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [ebj_pkg::DELAY_WIDTH-1:0]    csr_wdata
);
   import ebj_pkg::*;

   logic [DELAY_WIDTH-1:0] base_delay;
   logic [DELAY_WIDTH-1:0] max_delay;

   seq_state_type state_ff, state_in;

   logic [UNIT_WIDTH-1:0]    delay_ff, delay_in;
   logic [ATTEMPT_WIDTH-1:0] remain_ff, remain_in;
   logic [JITTER_WIDTH-1:0]  jitter_ff, jitter_in;
   logic [SPREAD_WIDTH-1:0]  spread_ff, spread_in;
   logic [SPREAD_WIDTH-1:0]  rem_ff, rem_in;
   logic [BIT_CNT_WIDTH-1:0] bit_cnt_ff, bit_cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [WAIT_WIDTH-1:0]    wait_ff, wait_in;

   unit_op_type  unit_op;
   unit_res_type unit_res;

   logic [SPREAD_WIDTH:0]   rem_shift;
   logic [DELAY_WIDTH-1:0]  capped;

   ebj_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .base_delay (base_delay),
      .max_delay  (max_delay)
   );

   ebj_sub u_sub (
      .op  (unit_op),
      .res (unit_res)
   );

   assign rem_shift = {rem_ff, jitter_ff[JITTER_WIDTH-1]};

   always_comb begin
      state_in     = state_ff;
      delay_in     = delay_ff;
      remain_in    = remain_ff;
      jitter_in    = jitter_ff;
      spread_in    = spread_ff;
      rem_in       = rem_ff;
      bit_cnt_in   = bit_cnt_ff;
      wait_in      = wait_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = 1'b1;
      unit_op.a    = delay_ff;
      unit_op.b    = UNIT_WIDTH'(max_delay);
      capped       = delay_ff[DELAY_WIDTH-1:0];

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               delay_in  = UNIT_WIDTH'(base_delay);
               remain_in = (req_attempt_number == '0) ? '0
                                                      : req_attempt_number - 1'b1;
               jitter_in = req_jitter_value;
               state_in  = ST_DOUBLE;
            end
         end
         ST_DOUBLE: begin
            // borrow of delay - max means delay is still below the ceiling
            if (remain_ff != '0 && unit_res.borrow && delay_ff != '0) begin
               delay_in  = {delay_ff[UNIT_WIDTH-2:0], 1'b0};
               remain_in = remain_ff - 1'b1;
            end else begin
               state_in = ST_CAP;
            end
         end
         ST_CAP: begin
            unit_op.a = UNIT_WIDTH'(max_delay);
            unit_op.b = delay_ff;
            if (unit_res.borrow) begin
               capped = max_delay;
            end
            delay_in   = UNIT_WIDTH'(capped);
            spread_in  = SPREAD_WIDTH'(capped[DELAY_WIDTH-1:2]) + 1'b1;
            rem_in     = '0;
            bit_cnt_in = BIT_CNT_WIDTH'(JITTER_WIDTH - 1);
            state_in   = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            unit_op.a = UNIT_WIDTH'(rem_shift);
            unit_op.b = UNIT_WIDTH'(spread_ff);
            rem_in    = unit_res.borrow ? rem_shift[SPREAD_WIDTH-1:0]
                                        : unit_res.diff[SPREAD_WIDTH-1:0];
            jitter_in = {jitter_ff[JITTER_WIDTH-2:0], 1'b0};
            if (bit_cnt_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               bit_cnt_in = bit_cnt_ff - 1'b1;
            end
         end
         ST_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               wait_in      = WAIT_WIDTH'(delay_ff[DELAY_WIDTH-1:0])
                            + WAIT_WIDTH'(rem_ff);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      delay_ff   <= delay_in;
      remain_ff  <= remain_in;
      jitter_ff  <= jitter_in;
      spread_ff  <= spread_in;
      rem_ff     <= rem_in;
      bit_cnt_ff <= bit_cnt_in;
      wait_ff    <= wait_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_wait_ms = wait_ff;

endmodule

// ===== rtl/ebj_csr.sv =====
// Configuration registers: base delay and delay ceiling.
module ebj_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ebj_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [ebj_pkg::DELAY_WIDTH-1:0]    csr_wdata,
   output logic [ebj_pkg::DELAY_WIDTH-1:0]    base_delay,
   output logic [ebj_pkg::DELAY_WIDTH-1:0]    max_delay
);
   import ebj_pkg::*;

   logic [DELAY_WIDTH-1:0] base_ff, base_in;
   logic [DELAY_WIDTH-1:0] max_ff, max_in;

   assign csr_ready = 1'b1;

   always_comb begin
      base_in = base_ff;
      max_in  = max_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_BASE_DELAY: base_in = csr_wdata;
            CSR_MAX_DELAY:  max_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_DELAY_RESET;
         max_ff  <= MAX_DELAY_RESET;
      end else begin
         base_ff <= base_in;
         max_ff  <= max_in;
      end
   end

   assign base_delay = base_ff;
   assign max_delay  = max_ff;

endmodule

// ===== rtl/ebj_sub.sv =====
// Shared subtract/compare unit used by the doubling, cap and divide steps.
module ebj_sub (
   input  ebj_pkg::unit_op_type  op,
   output ebj_pkg::unit_res_type res
);
   import ebj_pkg::*;

   logic [UNIT_WIDTH:0] full;

   assign full       = {1'b0, op.a} - {1'b0, op.b};
   assign res.borrow = full[UNIT_WIDTH];
   assign res.diff   = full[UNIT_WIDTH-1:0];

endmodule
